// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the run expander RTL; only the controller uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define RRE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: property failed");

// The expression must never be true outside reset.
`define RRE_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

// ----- hw/rtl/rre_pkg.sv -----
// ----------------------------------------------------------------------------
// rre_pkg
// Types and constants shared by the run expander modules.
// ----------------------------------------------------------------------------
package rre_pkg;

	localparam int unsigned CHUNK_BYTES = 8;
	localparam int unsigned DATA_W      = 64;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned LEN_W       = 9;
	localparam int unsigned WRITTEN_W   = 17;
	localparam int unsigned LIMIT_W     = 16;
	localparam int unsigned APB_AW      = 4;
	localparam int unsigned APB_DW      = 32;

	// Register indexes (byte address divided by four).
	localparam logic [1:0] REG_FILL_CODE = 2'd0;
	localparam logic [1:0] REG_FF_RUNS   = 2'd1;
	localparam logic [1:0] REG_OUT_LIMIT = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0]         FILL_CODE_RST = 8'h10;
	localparam logic [LIMIT_W-1:0] OUT_LIMIT_RST = 16'hFFFF;

	// Code nibbles and run byte values.
	localparam logic [3:0] NIB_ZERO_RUN = 4'h4;
	localparam logic [3:0] NIB_FF_RUN   = 4'hD;
	localparam logic [7:0] BYTE_FILL    = 8'hAA;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] BYTE_FF      = 8'hFF;
	localparam logic [LEN_W-1:0] LEN_FULL = 9'h100;

	typedef struct packed {
		logic [7:0]         fill_code;
		logic               ff_runs_enable;
		logic [LIMIT_W-1:0] output_limit;
	} cfg_t;

	// Controller to datapath.
	typedef struct packed {
		logic accept;   // input request taken this cycle
		logic step;     // load the next chunk of the current run
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic more;        // the incoming item gives more than one result
		logic last_chunk;  // the pending run fits in one chunk
	} sts_t;

endpackage

// ----- hw/rtl/rle_run_expander_top.sv -----
// ----------------------------------------------------------------------------
// rle_run_expander_top
// Run-length expander: one code byte in, packed chunks of output bytes out.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Content
// s_*       in         code_byte (8 bits) per request
// m_*       out        data_bytes, byte_count in tdata; last in tlast;
//                      done_res and overflow in tuser
// APB       in         fill_code @0x0, ff_runs_enable @0x4, output_limit @0x8
//
// A literal, terminator or overflow request gives a single chunk, and a new
// request is taken every cycle while the consumer keeps up.
// A run of L bytes gives ceil(L / 8) output chunks, and the chunk sequencer
// in the controller holds off the input until the last chunk of the run has
// been loaded into the output register.
// The output register takes a new request only when it is empty or its
// chunk is taken in the same cycle; a stalled consumer stalls both the chunk
// sequence and the input.
// Reset is asynchronous and active low; it clears the stream byte count,
// the run state, the output valid flag and restores the register defaults.
// ----------------------------------------------------------------------------
module rle_run_expander_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream.
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] code_byte
	// Output stream.
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [71:0]                 m_tdata,   // [63:0] data_bytes, [67:64] byte_count,
	                                               // [71:68] zero
	output logic                        m_tlast,   // last
	output logic [1:0]                  m_tuser,   // [0] done_res, [1] overflow
	// Configuration port.
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rre_pkg::APB_AW-1:0]  paddr,
	input  logic [rre_pkg::APB_DW-1:0]  pwdata,
	output logic [rre_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import rre_pkg::*;

	cfg_t               cfg_q;
	cmd_t               cmd;
	sts_t               sts;
	logic               wr_en;
	logic [1:0]         reg_idx;
	logic [DATA_W-1:0]  data_bytes;
	logic [COUNT_W-1:0] byte_count;
	logic               last;
	logic               done_res;
	logic               overflow;

	// The register file is written in the access phase; the low address bits
	// are ignored, so each register covers one 32-bit word.
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fill_code      <= FILL_CODE_RST;
			cfg_q.ff_runs_enable <= 1'b0;
			cfg_q.output_limit   <= OUT_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FILL_CODE: cfg_q.fill_code      <= pwdata[7:0];
				REG_FF_RUNS:   cfg_q.ff_runs_enable <= pwdata[0];
				REG_OUT_LIMIT: cfg_q.output_limit   <= pwdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reads return the register contents zero-extended to the bus width.
	always_comb begin
		unique case (reg_idx)
			REG_FILL_CODE: prdata = APB_DW'(cfg_q.fill_code);
			REG_FF_RUNS:   prdata = APB_DW'(cfg_q.ff_runs_enable);
			REG_OUT_LIMIT: prdata = APB_DW'(cfg_q.output_limit);
			default:       prdata = '0;
		endcase
	end

	// The controller owns the handshakes and the chunk sequence.
	rre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath decodes the code byte, checks the output limit and builds
	// each chunk into the output register.
	rre_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.code_byte  (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.data_bytes (data_bytes),
		.byte_count (byte_count),
		.last       (last),
		.done_res   (done_res),
		.overflow   (overflow)
	);

	assign m_tdata = {4'h0, byte_count, data_bytes};
	assign m_tlast = last;
	assign m_tuser = {overflow, done_res};

endmodule

// ----- hw/rtl/rre_dpath.sv -----
// ----------------------------------------------------------------------------
// rre_dpath
// Code decode, stream byte accounting, run state and the output register.
// ----------------------------------------------------------------------------
module rre_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rre_pkg::cfg_t                cfg,
	input  logic [7:0]                   code_byte,
	input  rre_pkg::cmd_t                cmd,
	output rre_pkg::sts_t                sts,
	output logic [rre_pkg::DATA_W-1:0]   data_bytes,
	output logic [rre_pkg::COUNT_W-1:0]  byte_count,
	output logic                         last,
	output logic                         done_res,
	output logic                         overflow
);
	import rre_pkg::*;

	function automatic logic [DATA_W-1:0] fill_chunk(input logic [7:0] v,
			input logic [COUNT_W-1:0] n);
		logic [DATA_W-1:0] d;
		d = '0;
		for (int i = 0; i < CHUNK_BYTES; i++) begin
			if (COUNT_W'(i) < n) begin
				d[8*i +: 8] = v;
			end
		end
		return d;
	endfunction

	logic [WRITTEN_W-1:0] bytes_written_q;
	logic [7:0]           run_value_q;
	logic [LEN_W-1:0]     run_remaining_q;

	logic [7:0]           val;
	logic                 is_run;
	logic [LEN_W-1:0]     len;
	logic                 lim_hit;
	logic [WRITTEN_W:0]   sum;
	logic                 ovf;
	logic                 term;
	logic [LEN_W-1:0]     src_len;
	logic [7:0]           src_val;
	logic                 src_fits;
	logic [COUNT_W-1:0]   take;

	always_comb begin
		is_run = 1'b1;
		val    = code_byte;
		priority if (cfg.fill_code == {code_byte[7:4], 4'h0}) begin
			val = BYTE_FILL;
		end else if (code_byte[7:4] == NIB_ZERO_RUN) begin
			val = BYTE_ZERO;
		end else if (cfg.ff_runs_enable && code_byte[7:4] == NIB_FF_RUN) begin
			val = BYTE_FF;
		end else begin
			is_run = 1'b0;
		end
		if (!is_run) begin
			len = LEN_W'(1);
		end else if (code_byte[3:0] == 4'h0) begin
			len = LEN_FULL;
		end else begin
			len = LEN_W'(code_byte[3:0]);
		end
	end

	assign lim_hit = bytes_written_q >= WRITTEN_W'(cfg.output_limit);
	assign sum     = (WRITTEN_W+1)'(bytes_written_q) + (WRITTEN_W+1)'(len);
	assign term    = code_byte == 8'h00;
	assign ovf     = lim_hit || (!term && sum > (WRITTEN_W+1)'(cfg.output_limit));

	// One chunk builder serves the first chunk of a new item and later chunks.
	assign src_len  = cmd.accept ? len : run_remaining_q;
	assign src_val  = cmd.accept ? val : run_value_q;
	assign src_fits = src_len <= LEN_W'(CHUNK_BYTES);
	assign take     = src_fits ? src_len[COUNT_W-1:0] : COUNT_W'(CHUNK_BYTES);

	assign sts.more       = !ovf && !term && !(len <= LEN_W'(CHUNK_BYTES));
	assign sts.last_chunk = run_remaining_q <= LEN_W'(CHUNK_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_written_q <= '0;
			run_value_q     <= '0;
			run_remaining_q <= '0;
		end else if (cmd.accept) begin
			if (ovf || term) begin
				bytes_written_q <= '0;
				run_value_q     <= '0;
				run_remaining_q <= '0;
			end else begin
				bytes_written_q <= sum[WRITTEN_W-1:0];
				run_value_q     <= val;
				run_remaining_q <= len - LEN_W'(take);
			end
		end else if (cmd.step) begin
			run_remaining_q <= run_remaining_q - LEN_W'(take);
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.accept && (ovf || term)) begin
			data_bytes <= '0;
			byte_count <= '0;
			last       <= 1'b1;
			done_res   <= !ovf;
			overflow   <= ovf;
		end else if (cmd.accept || cmd.step) begin
			data_bytes <= fill_chunk(src_val, take);
			byte_count <= take;
			last       <= src_fits;
			done_res   <= 1'b0;
			overflow   <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/rre_ctrl.sv -----
// ----------------------------------------------------------------------------
// rre_ctrl
// Sequencer for item intake, run chunk emission and the output valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rre_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  rre_pkg::sts_t sts,
	output rre_pkg::cmd_t cmd
);
	import rre_pkg::*;

	typedef enum logic [0:0] {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	// The output register can take new data when empty or being drained.
	assign slot_free  = !out_valid_q || m_tready;
	assign s_tready   = (state_q == S_IDLE) && slot_free;
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.step   = (state_q == S_RUN) && slot_free;
	assign m_tvalid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						out_valid_q <= 1'b1;
						if (sts.more) begin
							state_q <= S_RUN;
						end
					end else if (m_tready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (sts.last_chunk) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRE_NEVER(a_accept_and_step, clk, arst_n, cmd.accept && cmd.step)
	`RRE_ASSERT(a_multi_enters_run, clk, arst_n, (cmd.accept && sts.more) |=> (state_q == S_RUN && out_valid_q))
	`RRE_ASSERT(a_final_chunk_leaves_run, clk, arst_n, (cmd.step && sts.last_chunk) |=> (state_q == S_IDLE && out_valid_q))

endmodule

// ----- tb/rre_expand_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_expand_checker
// Watches the code, chunk and register channels of the run expander, predicts
// every output chunk from the accepted code bytes and compares field by field.
// ----------------------------------------------------------------------------
module rre_expand_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] code_byte
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [71:0]                  m_tdata,   // [63:0] data_bytes, [67:64] byte_count
	input  logic                         m_tlast,   // last
	input  logic [1:0]                   m_tuser,   // [0] done_res, [1] overflow
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rre_pkg::APB_AW-1:0]   paddr,
	input  logic [rre_pkg::APB_DW-1:0]   pwdata,
	input  logic                         pready,
	output int                           mismatches,
	output int                           chunks_waiting
);
	import rre_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic               last;
		logic               done;
		logic               ovf;
	} out_chunk_t;

	logic [7:0]           fill_code;
	logic                 ff_runs;
	logic [LIMIT_W-1:0]   out_limit;
	logic [WRITTEN_W-1:0] stream_bytes;
	out_chunk_t           chunks_due[$];

	initial mismatches = 0;

	// A terminator or an overflow gives one empty chunk and restarts the stream.
	function automatic void push_marker(input logic done, input logic ovf);
		out_chunk_t c;
		c.data  = '0;
		c.count = '0;
		c.last  = 1'b1;
		c.done  = done;
		c.ovf   = ovf;
		chunks_due.push_back(c);
		stream_bytes = '0;
	endfunction

	function automatic void expand_code(input logic [7:0] code);
		int unsigned run_len;
		int unsigned left;
		int unsigned take;
		int unsigned k;
		logic [7:0]  run_byte;
		logic        is_run;
		out_chunk_t  c;
		is_run   = 1'b1;
		run_byte = code;
		if (int'(stream_bytes) >= int'(out_limit)) begin
			push_marker(1'b0, 1'b1);
			return;
		end
		if (code == 8'h00) begin
			push_marker(1'b1, 1'b0);
			return;
		end
		// The fill code wins over the fixed nibbles, and the 0xFF run only
		// exists while it is enabled.
		if ({code[7:4], 4'h0} == fill_code)
			run_byte = BYTE_FILL;
		else if (code[7:4] == NIB_ZERO_RUN)
			run_byte = BYTE_ZERO;
		else if (ff_runs && code[7:4] == NIB_FF_RUN)
			run_byte = BYTE_FF;
		else
			is_run = 1'b0;
		run_len = 1;
		if (is_run)
			run_len = (code[3:0] == 4'h0) ? int'(LEN_FULL) : int'(code[3:0]);
		if (int'(stream_bytes) + run_len > int'(out_limit)) begin
			push_marker(1'b0, 1'b1);
			return;
		end
		stream_bytes = stream_bytes + WRITTEN_W'(run_len);
		left = run_len;
		while (left > 0) begin
			take   = (left > CHUNK_BYTES) ? CHUNK_BYTES : left;
			c.data = '0;
			for (k = 0; k < take; k++)
				c.data[8*k +: 8] = run_byte;
			left    = left - take;
			c.count = COUNT_W'(take);
			c.last  = (left == 0);
			c.done  = 1'b0;
			c.ovf   = 1'b0;
			chunks_due.push_back(c);
		end
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_chunk();
		out_chunk_t want;
		out_chunk_t got;
		got.data  = m_tdata[63:0];
		got.count = m_tdata[67:64];
		got.last  = m_tlast;
		got.done  = m_tuser[0];
		got.ovf   = m_tuser[1];
		if (chunks_due.size() == 0) begin
			$display("%0t: unexpected chunk, expected none, actual data %0h count %0d",
				$time, got.data, got.count);
			mismatches++;
			return;
		end
		want = chunks_due.pop_front();
		check_field("data_bytes", want.data, got.data);
		check_field("byte_count", 64'(want.count), 64'(got.count));
		check_field("last", 64'(want.last), 64'(got.last));
		check_field("done_res", 64'(want.done), 64'(got.done));
		check_field("overflow", 64'(want.ovf), 64'(got.ovf));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_code    = FILL_CODE_RST;
			ff_runs      = 1'b0;
			out_limit    = OUT_LIMIT_RST;
			stream_bytes = '0;
			chunks_due.delete();
			chunks_waiting <= 0;
		end else begin
			if (m_tvalid && m_tready)
				compare_chunk();
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FILL_CODE: fill_code = pwdata[7:0];
					REG_FF_RUNS:   ff_runs   = pwdata[0];
					REG_OUT_LIMIT: out_limit = pwdata[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expand_code(s_tdata);
			chunks_waiting <= chunks_due.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives code bytes and register writes into the run expander and lets the
// checker predict and compare the packed output chunks.
// ----------------------------------------------------------------------------
module testbench;
	import rre_pkg::*;

	// A zero code byte closes the stream.
	localparam logic [7:0] TERMINATOR = 8'h00;
	// Cycles the consumer refuses chunks while the producer keeps pushing.
	localparam int LONG_HOLD = 300;
	// Cycles without a handshake on either stream before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 4000;
	// Settling time after the last chunk has been seen.
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_PHASES = 5;
	localparam int CODES_PER_PHASE = 15;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] code_byte
	logic              m_tvalid;
	logic              m_tready;
	logic [71:0]       m_tdata;   // [63:0] data_bytes, [67:64] byte_count, [71:68] zero
	logic              m_tlast;   // last
	logic [1:0]        m_tuser;   // [0] done_res, [1] overflow
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int                mismatches;
	int                chunks_waiting;
	int                idle_cycles;
	int unsigned       burst_left;
	bit                hold_req;
	logic [7:0]        code_q[$];

	always #5 clk = ~clk;

	rle_run_expander_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	rre_expand_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatches     (mismatches),
		.chunks_waiting (chunks_waiting)
	);

	// The watchdog only looks at the two streams. Register writes happen
	// right after an idle point and are short, so they never come near
	// the limit.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("rle_run_expander_top verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Consumer side. It switches between stretches of full speed, light
	// stalling and heavy stalling. Once the stimulus asks for it, it refuses
	// chunks for a long stretch so that the output register and then the
	// input back up.
	initial begin
		int unsigned stretch;
		int unsigned stall_pct;
		bit          held;
		stretch   = 0;
		stall_pct = 0;
		held      = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (stretch == 0) begin
				stretch = $urandom_range(10, 60);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 40;
					default: stall_pct = 85;
				endcase
			end
			stretch--;
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// One code byte request. The producer works in bursts; at the start of
	// each burst it may sit idle for a random gap. A zero gap keeps tvalid
	// high across bursts, so tvalid is only lowered when a gap really follows.
	task automatic send_code(input logic [7:0] code);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	// Sends every queued code byte, then waits until the checker holds no
	// outstanding chunk. Every code byte gives at least one chunk, so an
	// empty expectation store means the block is idle.
	task automatic send_queue();
		while (code_q.size() > 0)
			send_code(code_q.pop_front());
		s_tvalid <= 1'b0;
		do @(posedge clk); while (chunks_waiting != 0);
	endtask

	// Register write: a setup phase, then an access phase that completes when
	// pready is high. The bus then returns to idle so that back-to-back writes
	// never lower and raise psel in the same step.
	task automatic reg_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] fill, input logic ff_on,
			input logic [LIMIT_W-1:0] limit);
		reg_write(REG_FILL_CODE, APB_DW'(fill));
		reg_write(REG_FF_RUNS, APB_DW'(ff_on));
		reg_write(REG_OUT_LIMIT, APB_DW'(limit));
	endtask

	// Random streams are mostly runs on the active nibbles, with literals
	// (any nonzero byte value) and the occasional terminator mixed in. A low nibble
	// of zero asks for the longest run.
	function automatic logic [7:0] pick_code(input logic [7:0] fill);
		int unsigned sel;
		logic [3:0]  len;
		sel = $urandom_range(0, 99);
		len = ($urandom_range(0, 5) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
		if (sel < 8)
			return TERMINATOR;
		else if (sel < 30)
			return {fill[7:4], len};
		else if (sel < 50)
			return {NIB_ZERO_RUN, len};
		else if (sel < 62)
			return {NIB_FF_RUN, len};
		else
			return 8'($urandom_range(1, 255));
	endfunction

	initial begin
		logic [7:0]         fill;
		logic               ff_on;
		logic [LIMIT_W-1:0] limit;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		idle_cycles <= 0;
		hold_req    = 1'b0;
		burst_left  = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults: literals at both ends of the byte range, fill
		// runs of full and partial length, zero runs, a 0xD code while 0xFF
		// runs are still disabled, and a terminator.
		code_q = '{8'h01, 8'hFF, 8'h80, 8'h10, 8'h1F, 8'h11, 8'h40, 8'h41, 8'h4F,
			8'hD3, TERMINATOR};
		send_queue();

		// A fill code with a nonzero low nibble never matches. With a limit of
		// 40 bytes a 256-byte run overflows, a run that lands exactly on the
		// limit is allowed, and the next byte overflows because the limit is
		// already reached. The terminator then starts from an empty stream.
		set_config(8'h13, 1'b1, 16'd40);
		code_q = '{8'h13, 8'hD0, 8'hD8, 8'hDF, 8'h4F, 8'h42, 8'h01, TERMINATOR};
		send_queue();

		// A fill code of zero turns small nonzero bytes into fill runs.
		set_config(8'h00, 1'b0, 16'hFFFF);
		code_q = '{8'h05, TERMINATOR};
		send_queue();

		// With no room at all even the terminator reports an overflow.
		set_config(8'hD0, 1'b1, 16'h0000);
		code_q = '{8'hD2, TERMINATOR};
		send_queue();

		// The fill code takes priority over the zero-run nibble.
		set_config(8'h40, 1'b0, 16'd300);
		code_q = '{8'h40, 8'h4F, 8'hD2, TERMINATOR};
		send_queue();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: fill = {4'($urandom_range(0, 15)), 4'h0};
				1: fill = 8'($urandom);
				2: fill = 8'h00;
				default: fill = 8'hFF;
			endcase
			ff_on = 1'($urandom);
			case ($urandom_range(0, 4))
				0: limit = '0;
				1: limit = 16'hFFFF;
				2, 3: limit = 16'($urandom_range(1, 600));
				default: limit = 16'($urandom);
			endcase
			set_config(fill, ff_on, limit);
			for (int n = 0; n < CODES_PER_PHASE; n++)
				code_q.push_back(pick_code(fill));
			if (p == 1)
				hold_req = 1'b1;
			send_queue();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("rle_run_expander_top verification clean");
		end else begin
			$display("rle_run_expander_top verification failed");
		end
		$finish;
	end

endmodule
